// ===== design/tdc_hit_period_residual_core_defines.svh =====
// Assertion macros for the TDC hit period residual core.
// Used by the checker; depends on nothing else.
`ifndef TDC_HIT_PERIOD_RESIDUAL_CORE_DEFINES_SVH
`define TDC_HIT_PERIOD_RESIDUAL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THPR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("thpr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define THPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("thpr: next-cycle check failed");

`endif

// ===== design/thpr_pkg.sv =====
// Shared types, constants and helpers of the TDC hit period residual core.
// No dependencies; imported by thpr_cfg, thpr_alu, thpr_mul, the core and the testbench.
package thpr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_SUB_TDC = 4;

	localparam logic [3:0] WORD_PIXEL_HIT = 4'd1;
	localparam logic [3:0] WORD_SPILL_START = 4'd7;

	localparam int NOMINAL_SPACING = 320;
	localparam int SPACING_TOL = 10;

	localparam int RES_W = 48;
	localparam int SUM_W = 64;
	localparam int PAIR_W = 32;
	localparam int MUL_W = 32;
	localparam int CEXT_W = 31;

	typedef enum logic [1:0] {
		CFG_TARGET  = 2'd0,
		CFG_OFFSETS = 2'd1,
		CFG_SLOPES  = 2'd2,
		CFG_PERIOD  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [4:0]  target_channel;
		logic [63:0] tdc_offsets;
		logic [63:0] tdc_slopes;
		logic [31:0] expected_period;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		target_channel:  5'd0,
		tdc_offsets:     64'h8000_8000_8000_8000,
		tdc_slopes:      64'h03FE_03FE_03FE_03FE,
		expected_period: 32'd20971520
	};

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// Picks the 16-bit lane of a packed register for a sub-TDC. Codes past the
	// last sub-TDC fall back to the last one.
	function automatic logic [15:0] lane16(input logic [63:0] packed_val,
			input logic [1:0] sub);
		logic [2:0]  k;
		logic [63:0] sh;
		if (32'(sub) >= NUM_SUB_TDC) begin
			k = 3'(NUM_SUB_TDC - 1);
		end else begin
			k = {1'b0, sub};
		end
		sh = packed_val >> {k[1:0], 4'b0000};
		return sh[15:0];
	endfunction

endpackage

// ===== design/thpr_if.sv =====
// Valid/ready channel interfaces for hit words and residual results.
// Depends on nothing else.
interface thpr_hit_if;
	logic       valid;
	logic       ready;
	logic [3:0] word_type;
	logic [2:0] column;
	logic [1:0] pixel;
	logic [1:0] sub_tdc;
	logic [15:0] rollover;
	logic [14:0] coarse_count;
	logic [8:0] fine_count;

	modport source (output valid, word_type, column, pixel, sub_tdc, rollover,
		coarse_count, fine_count, input ready);
	modport sink (input valid, word_type, column, pixel, sub_tdc, rollover,
		coarse_count, fine_count, output ready);
endinterface

interface thpr_result_if;
	logic              valid;
	logic              ready;
	logic signed [47:0] residual;
	logic              in_window;
	logic [63:0]       square_sum;
	logic [31:0]       pair_count;

	modport source (output valid, residual, in_window, square_sum, pair_count,
		input ready);
	modport sink (input valid, residual, in_window, square_sum, pair_count,
		output ready);
endinterface

// ===== design/thpr_cfg.sv =====
// Configuration register file of the TDC hit period residual core.
// Depends on thpr_pkg.
module thpr_cfg
	import thpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [1:0]  index,
	input  logic [63:0] wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (we) begin
			unique case (cfg_idx_t'(index))
				CFG_TARGET:  cfg_q.target_channel <= wdata[4:0];
				CFG_OFFSETS: cfg_q.tdc_offsets <= wdata;
				CFG_SLOPES:  cfg_q.tdc_slopes <= wdata;
				CFG_PERIOD:  cfg_q.expected_period <= wdata[31:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/thpr_alu.sv =====
// Shared add/subtract unit used by every add and subtract step of the sequencer.
// Depends on thpr_pkg.
module thpr_alu
	import thpr_pkg::*;
#(
	parameter int W = 66
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  alu_op_t      op,
	output logic [W-1:0] y
);

	always_comb begin
		unique case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
		endcase
	end

endmodule

// ===== design/thpr_mul.sv =====
// Shared unsigned multiplier for the fine-time slope and the residual square.
// Depends on thpr_pkg; the product is registered by the sequencer.
module thpr_mul
	import thpr_pkg::*;
(
	input  logic [MUL_W-1:0]   a,
	input  logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0] y
);

	assign y = a * b;

endmodule

// ===== design/tdc_hit_period_residual_core.sv =====
// Top level of the TDC hit period residual core: sequencer and state.
// Depends on thpr_pkg, thpr_if, thpr_cfg, thpr_alu and thpr_mul.
//
// Channel   Direction  Handshake          Payload
// hits      in         valid/ready        word_type, column, pixel, sub_tdc,
//                                         rollover, coarse_count, fine_count
// results   out        valid/ready        residual, in_window, square_sum,
//                                         pair_count
// cfg       in         cfg_we, no wait    cfg_index, cfg_wdata
//
// A word that is not a hit on the target channel leaves the sequencer in idle.
// The first hit of a spill only runs MULC, ADDC and TIME; every later hit runs
// ten sequencer steps through the one shared adder and multiplier.
// The next word is accepted while a finished result waits on the output.
// If the previous result is still held, the sequencer waits in its last step.
// Reset clears the sequencer, the previous-hit flag, the sum and the count.
module tdc_hit_period_residual_core
	import thpr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	thpr_hit_if.sink    hits,
	thpr_result_if.source results
);

	localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SH_R = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
	localparam int DW = FRAC_BITS + 36;
	localparam int AW = (DW > SUM_W) ? DW + 2 : SUM_W + 2;
	localparam logic signed [AW-1:0] WIN_LO = AW'(NOMINAL_SPACING - SPACING_TOL);
	localparam logic signed [AW-1:0] WIN_HI = AW'(NOMINAL_SPACING + SPACING_TOL);
	localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_MULC = 11'b000_0000_0010,
		ST_ADDC = 11'b000_0000_0100,
		ST_TIME = 11'b000_0000_1000,
		ST_DIFF = 11'b000_0001_0000,
		ST_RES  = 11'b000_0010_0000,
		ST_SPC  = 11'b000_0100_0000,
		ST_ABS  = 11'b000_1000_0000,
		ST_SQ   = 11'b001_0000_0000,
		ST_ACC  = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	cfg_t cfg;

	state_t state_q;
	logic   have_prev_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PAIR_W-1:0] pairs_q;
	logic              out_valid_q;

	logic [1:0]          sub_q;
	logic [8:0]          fine_q;
	logic [CEXT_W-1:0]   cext_q;
	logic [CEXT_W-1:0]   prev_cext_q;
	logic [AW-1:0]       prev_time_q;
	logic [AW-1:0]       alu_q;
	logic [2*MUL_W-1:0]  mul_q;
	logic [RES_W-1:0]    res_q;
	logic                win_q;
	logic                big_q;
	logic [MUL_W-1:0]    mag_q;
	logic [RES_W-1:0]    out_res_q;
	logic                out_win_q;
	logic [SUM_W-1:0]    out_sum_q;
	logic [PAIR_W-1:0]   out_pairs_q;

	logic [AW-1:0]      alu_a;
	logic [AW-1:0]      alu_b;
	alu_op_t            alu_op;
	logic [AW-1:0]      alu_y;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] mul_y;

	logic [15:0]        off_lane;
	logic [15:0]        slope_lane;
	logic               accept;
	logic               out_load;
	logic               hit_match;
	logic [AW-RES_W:0]  res_upper;
	logic [RES_W-1:0]   res_sat;
	logic [SUM_W-1:0]   sq_val;

	thpr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	thpr_alu #(.W(AW)) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.y  (alu_y)
	);

	thpr_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.y (mul_y)
	);

	assign off_lane = lane16(cfg.tdc_offsets, sub_q);
	assign slope_lane = lane16(cfg.tdc_slopes, sub_q);

	assign hits.ready = (state_q == ST_IDLE);
	assign accept = hits.valid && hits.ready;
	assign hit_match = (hits.word_type == WORD_PIXEL_HIT) &&
		({hits.column, hits.pixel} == cfg.target_channel);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	// Saturate the residual to the signed 48-bit range.
	assign res_upper = alu_y[AW-1:RES_W-1];
	always_comb begin
		if ((&res_upper) || !(|res_upper)) begin
			res_sat = alu_y[RES_W-1:0];
		end else if (alu_y[AW-1]) begin
			res_sat = RES_MIN;
		end else begin
			res_sat = RES_MAX;
		end
	end

	assign sq_val = big_q ? {SUM_W{1'b1}} : mul_q;

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_op = ALU_ADD;
		mul_a = MUL_W'(fine_q);
		mul_b = MUL_W'(slope_lane);
		unique case (state_q)
			ST_ADDC: begin
				alu_a = AW'(off_lane >> SH_R) << SH_L;
				alu_b = AW'(mul_q[24:0] >> SH_R) << SH_L;
			end
			ST_TIME: begin
				alu_a = AW'(cext_q) << FRAC_BITS;
				alu_b = alu_q;
				alu_op = ALU_SUB;
			end
			ST_DIFF: begin
				alu_a = alu_q;
				alu_b = prev_time_q;
				alu_op = ALU_SUB;
			end
			ST_RES: begin
				alu_a = alu_q;
				alu_b = AW'(cfg.expected_period >> SH_R) << SH_L;
				alu_op = ALU_SUB;
			end
			ST_SPC: begin
				alu_a = AW'(cext_q);
				alu_b = AW'(prev_cext_q);
				alu_op = ALU_SUB;
			end
			ST_ABS: begin
				alu_b = {{(AW-RES_W){res_q[RES_W-1]}}, res_q};
				alu_op = res_q[RES_W-1] ? ALU_SUB : ALU_ADD;
			end
			ST_SQ: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
			ST_ACC: begin
				alu_a = AW'(sum_q);
				alu_b = AW'(sq_val);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_prev_q <= 1'b0;
			sum_q <= '0;
			pairs_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (hits.word_type == WORD_SPILL_START) begin
							have_prev_q <= 1'b0;
						end else if (hit_match) begin
							state_q <= ST_MULC;
						end
					end
				end
				ST_MULC: state_q <= ST_ADDC;
				ST_ADDC: state_q <= ST_TIME;
				ST_TIME: begin
					if (have_prev_q) begin
						state_q <= ST_DIFF;
					end else begin
						have_prev_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIFF: state_q <= ST_RES;
				ST_RES:  state_q <= ST_SPC;
				ST_SPC:  state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_ACC;
				ST_ACC: begin
					if (win_q) begin
						sum_q <= alu_y[SUM_W] ? {SUM_W{1'b1}} : alu_y[SUM_W-1:0];
						if (pairs_q != {PAIR_W{1'b1}}) begin
							pairs_q <= pairs_q + PAIR_W'(1);
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sub_q <= hits.sub_tdc;
			fine_q <= hits.fine_count;
			cext_q <= {hits.rollover, hits.coarse_count};
		end
		if (state_q == ST_MULC || state_q == ST_SQ) begin
			mul_q <= mul_y;
		end
		if (state_q == ST_ADDC || state_q == ST_TIME || state_q == ST_DIFF) begin
			alu_q <= alu_y;
		end
		if (state_q == ST_TIME && !have_prev_q) begin
			prev_time_q <= alu_y;
			prev_cext_q <= cext_q;
		end
		if (state_q == ST_DIFF) begin
			prev_time_q <= alu_q;
		end
		if (state_q == ST_RES) begin
			res_q <= res_sat;
		end
		if (state_q == ST_SPC) begin
			win_q <= ($signed(alu_y) > WIN_LO) && ($signed(alu_y) < WIN_HI);
			prev_cext_q <= cext_q;
		end
		if (state_q == ST_ABS) begin
			big_q <= |alu_y[RES_W-1:MUL_W];
			mag_q <= alu_y[MUL_W-1:0];
		end
		if (out_load) begin
			out_res_q <= res_q;
			out_win_q <= win_q;
			out_sum_q <= sum_q;
			out_pairs_q <= pairs_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.residual = $signed(out_res_q);
	assign results.in_window = out_win_q;
	assign results.square_sum = out_sum_q;
	assign results.pair_count = out_pairs_q;

endmodule

// ===== design/thpr_checker.sv =====
// Port-level checks of the TDC hit period residual core, bound to the top.
// Depends on tdc_hit_period_residual_core_defines.svh.
`include "tdc_hit_period_residual_core_defines.svh"

module thpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] residual,
	input logic        in_window,
	input logic [63:0] square_sum,
	input logic [31:0] pair_count
);

	// A held result keeps its payload until the transaction completes.
	`THPR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(residual) && $stable(in_window) && $stable(square_sum) && $stable(pair_count))

	// No result can be produced in the cycle right after an input transaction.
	`THPR_ASSERT_NEXT(a_no_fast_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

	// Delivering a result returns the sequencer to idle.
	`THPR_ASSERT_SAME(a_idle_after_result, clk, arst_n, $rose(out_valid), in_ready)

	// An accepted pair has always been counted.
	`THPR_ASSERT_SAME(a_window_counted, clk, arst_n, out_valid && in_window, pair_count != 32'd0)

endmodule

bind tdc_hit_period_residual_core thpr_checker u_thpr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (hits.valid),
	.in_ready   (hits.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.residual   (results.residual),
	.in_window  (results.in_window),
	.square_sum (results.square_sum),
	.pair_count (results.pair_count)
);

// ===== tb/tdc_hit_period_residual_core_test.sv =====
// Self-checking regression for the TDC hit period residual core.
// Needs thpr_pkg, the thpr_hit_if and thpr_result_if interfaces and the core itself.
// A scoreboard class predicts every residual; plain tasks drive hit words and settings.
`timescale 1ns / 100ps

module tdc_hit_period_residual_core_test;
	import thpr_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int MAX_REPORTS = 10;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam logic [3:0] WORD_UNUSED = 4'hF;
	localparam longint RESIDUAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint RESIDUAL_MIN = -64'sh0000_8000_0000_0000;

	typedef struct packed {
		logic [3:0]  word_type;
		logic [2:0]  column;
		logic [1:0]  pixel;
		logic [1:0]  sub_tdc;
		logic [15:0] rollover;
		logic [14:0] coarse_count;
		logic [8:0]  fine_count;
	} hit_word_t;

	typedef struct packed {
		logic [47:0] residual;
		logic        in_window;
		logic [63:0] square_sum;
		logic [31:0] pair_count;
	} residual_t;

	class residual_scoreboard;
		cfg_t        cfg = CFG_RESET;
		bit          have_previous;
		longint      previous_stamp;
		logic [30:0] previous_cext;
		logic [63:0] square_total;
		logic [31:0] pair_total;
		residual_t   pending_residuals[$];
		int unsigned hit_words;
		int unsigned results_seen;
		int unsigned window_results;
		int unsigned mismatches;

		function logic [63:0] to_q(logic [63:0] v);
			if (FRAC >= 16) begin
				return v << (FRAC - 16);
			end else begin
				return v >> (16 - FRAC);
			end
		endfunction

		function void note_hit(hit_word_t w);
			int          lane;
			logic [30:0] cext;
			logic [63:0] corr;
			logic [63:0] mag;
			logic [63:0] sq;
			logic [64:0] acc;
			longint      stamp;
			longint      delta;
			longint      spacing;
			residual_t   r;
			hit_words++;
			if (w.word_type == WORD_SPILL_START) begin
				have_previous = 1'b0;
				return;
			end
			if (w.word_type != WORD_PIXEL_HIT || {w.column, w.pixel} != cfg.target_channel) begin
				return;
			end
			lane = (int'(w.sub_tdc) >= NUM_SUB_TDC) ? NUM_SUB_TDC - 1 : int'(w.sub_tdc);
			cext = {w.rollover, w.coarse_count};
			corr = to_q(64'(cfg.tdc_offsets[lane*16 +: 16]))
				+ to_q(64'(w.fine_count) * 64'(cfg.tdc_slopes[lane*16 +: 16]));
			stamp = $signed(64'(cext) << FRAC) - $signed(corr);
			if (!have_previous) begin
				have_previous = 1'b1;
				previous_stamp = stamp;
				previous_cext = cext;
				return;
			end
			delta = stamp - previous_stamp - $signed(to_q(64'(cfg.expected_period)));
			if (delta > RESIDUAL_MAX) begin
				delta = RESIDUAL_MAX;
			end else if (delta < RESIDUAL_MIN) begin
				delta = RESIDUAL_MIN;
			end
			spacing = longint'(cext) - longint'(previous_cext) - NOMINAL_SPACING;
			r.in_window = (spacing < SPACING_TOL) && (spacing > -SPACING_TOL);
			if (r.in_window) begin
				mag = (delta < 0) ? 64'(-delta) : 64'(delta);
				sq = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
				acc = {1'b0, square_total} + {1'b0, sq};
				square_total = acc[64] ? '1 : acc[63:0];
				if (pair_total != '1) begin
					pair_total++;
				end
			end
			previous_stamp = stamp;
			previous_cext = cext;
			r.residual = delta[47:0];
			r.square_sum = square_total;
			r.pair_count = pair_total;
			pending_residuals.push_back(r);
		endfunction

		function void check_residual(residual_t got);
			residual_t want;
			results_seen++;
			if (pending_residuals.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("[%0t] residual %h arrived with no hit pending", $time,
						got.residual);
				end
				return;
			end
			want = pending_residuals.pop_front();
			if (want.in_window) begin
				window_results++;
			end
			if (got.residual !== want.residual || got.in_window !== want.in_window
					|| got.square_sum !== want.square_sum
					|| got.pair_count !== want.pair_count) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("[%0t] residual exp %h got %h, window exp %b got %b", $time,
						want.residual, got.residual, want.in_window, got.in_window);
					$display("    square sum exp %h got %h, pairs exp %0d got %0d",
						want.square_sum, got.square_sum, want.pair_count, got.pair_count);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	thpr_hit_if    hit_ch ();
	thpr_result_if res_ch ();

	residual_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned settings_run;
	int unsigned quiet_cycles;
	logic [30:0] seq_cext;

	tdc_hit_period_residual_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.hits      (hit_ch),
		.results   (res_ch)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			sb.check_residual(residual_t'{res_ch.residual, res_ch.in_window,
				res_ch.square_sum, res_ch.pair_count});
		end
	end

	always @(posedge clk) begin
		if ((hit_ch.valid && hit_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("tdc_hit_period_residual_core regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic hit_word_t random_fields();
		hit_word_t w;
		w.word_type = 4'($urandom);
		w.column = 3'($urandom);
		w.pixel = 2'($urandom);
		w.sub_tdc = 2'($urandom);
		w.rollover = 16'($urandom);
		w.coarse_count = 15'($urandom);
		w.fine_count = 9'($urandom);
		return w;
	endfunction

	function automatic hit_word_t spill_word();
		hit_word_t w;
		w = random_fields();
		w.word_type = WORD_SPILL_START;
		return w;
	endfunction

	function automatic hit_word_t make_hit(logic [4:0] chan, logic [30:0] cext,
			logic [1:0] sub, logic [8:0] fine);
		hit_word_t w;
		w.word_type = WORD_PIXEL_HIT;
		{w.column, w.pixel} = chan;
		{w.rollover, w.coarse_count} = cext;
		w.sub_tdc = sub;
		w.fine_count = fine;
		return w;
	endfunction

	function automatic logic [30:0] fresh_start();
		return ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4000));
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_word(hit_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			hit_ch.valid <= 1'b0;
			@(negedge clk);
		end
		hit_ch.valid <= 1'b1;
		hit_ch.word_type <= w.word_type;
		hit_ch.column <= w.column;
		hit_ch.pixel <= w.pixel;
		hit_ch.sub_tdc <= w.sub_tdc;
		hit_ch.rollover <= w.rollover;
		hit_ch.coarse_count <= w.coarse_count;
		hit_ch.fine_count <= w.fine_count;
		@(posedge clk);
		while (!hit_ch.ready) begin
			@(posedge clk);
		end
		sb.note_hit(w);
		@(negedge clk);
	endtask

	task automatic drain_results();
		hit_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_residuals.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
	endtask

	// First hits and ignored words give no result, so settle before writing.
	task automatic apply_setting(cfg_t s);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_TARGET, 64'(s.target_channel));
		write_reg(CFG_OFFSETS, s.tdc_offsets);
		write_reg(CFG_SLOPES, s.tdc_slopes);
		write_reg(CFG_PERIOD, 64'(s.expected_period));
		cfg_we <= 1'b0;
		sb.cfg = s;
		settings_run++;
	endtask

	task automatic random_word(output hit_word_t w);
		int unsigned pick;
		logic [31:0] step;
		pick = $urandom_range(0, 99);
		w = random_fields();
		if (pick < 6) begin
			w = spill_word();
			seq_cext = fresh_start();
		end else if (pick < 74) begin
			step = ($urandom_range(0, 19) == 0) ? $urandom : 32'(308 + $urandom_range(0, 24));
			seq_cext = seq_cext + step[30:0];
			w = make_hit(sb.cfg.target_channel, seq_cext, 2'($urandom_range(0, 3)),
				9'($urandom_range(0, 511)));
		end else if (pick < 86) begin
			w.word_type = WORD_PIXEL_HIT;
		end
	endtask

	task automatic random_stretch(int unsigned n);
		int unsigned counted;
		bit          paused;
		hit_word_t   w;
		counted = 0;
		paused = 1'b0;
		seq_cext = fresh_start();
		while (counted < n) begin
			random_word(w);
			send_word(w);
			counted++;
			if (!paused && counted >= n / 2) begin
				paused = 1'b1;
				drain_results();
			end
		end
	endtask

	initial begin
		cfg_t      s;
		hit_word_t w;
		sb = new;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET;
		cfg_wdata = '0;
		hit_ch.valid = 1'b0;
		hit_ch.word_type = '0;
		hit_ch.column = '0;
		hit_ch.pixel = '0;
		hit_ch.sub_tdc = '0;
		hit_ch.rollover = '0;
		hit_ch.coarse_count = '0;
		hit_ch.fine_count = '0;
		res_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		settings_run = 1;
		quiet_cycles = 0;
		seq_cext = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: spacing window edges, spill restart, wrap and saturation.
		send_word(spill_word());
		send_word(make_hit(5'd5, 31'd1000, 2'd0, 9'd0));
		w = make_hit(5'd0, 31'd1000, 2'd0, 9'd0);
		w.word_type = WORD_UNUSED;
		send_word(w);
		send_word(make_hit(5'd0, 31'd1000, 2'd0, 9'd0));
		send_word(make_hit(5'd0, 31'd1320, 2'd1, 9'd511));
		send_word(make_hit(5'd0, 31'd1631, 2'd2, 9'd100));
		send_word(make_hit(5'd0, 31'd1941, 2'd3, 9'd0));
		send_word(make_hit(5'd0, 31'd2270, 2'd0, 9'd255));
		send_word(make_hit(5'd0, 31'd2600, 2'd1, 9'd1));
		send_word(make_hit(5'd0, 31'h7FFF_FFFF, 2'd3, 9'd0));
		send_word(make_hit(5'd0, 31'd0, 2'd0, 9'd511));
		send_word(spill_word());
		send_word(make_hit(5'd0, 31'h7FFF_FEC0, 2'd2, 9'd17));
		send_word(make_hit(5'd0, 31'd0, 2'd1, 9'd300));
		send_word(make_hit(5'd0, 31'd320, 2'd3, 9'd511));
		random_stretch(100);

		s.target_channel = 5'd31;
		s.tdc_offsets = '1;
		s.tdc_slopes = '1;
		s.expected_period = '0;
		apply_setting(s);
		send_idle_pct = 64;
		send_word(spill_word());
		send_word(make_hit(5'd31, 31'd0, 2'd3, 9'd511));
		send_word(make_hit(5'd31, 31'h7FFF_FFFF, 2'd0, 9'd0));
		random_stretch(100);

		s.target_channel = 5'($urandom_range(0, 31));
		s.tdc_offsets = '0;
		s.tdc_slopes = '0;
		s.expected_period = 32'd20971520 + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		apply_setting(s);
		send_idle_pct = 0;
		recv_stall_pct = 64;
		random_stretch(100);

		s.target_channel = 5'($urandom_range(0, 31));
		s.tdc_offsets = {$urandom, $urandom};
		s.tdc_slopes = {$urandom, $urandom};
		s.expected_period = 32'd20971520 + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		apply_setting(s);
		send_idle_pct = 24;
		recv_stall_pct = 24;
		random_stretch(100);

		// A huge period with an in-window spacing drives the square and the sum to saturation.
		s.target_channel = 5'($urandom_range(0, 31));
		s.tdc_offsets = '1;
		s.tdc_slopes = '1;
		s.expected_period = '1;
		apply_setting(s);
		send_word(spill_word());
		send_word(make_hit(s.target_channel, 31'd0, 2'd0, 9'd0));
		send_word(make_hit(s.target_channel, 31'd311, 2'd3, 9'd511));
		send_word(make_hit(s.target_channel, 31'd631, 2'd1, 9'd0));
		random_stretch(30);

		drain_results();
		repeat (SETTLE_CYCLES + 8) @(negedge clk);
		$display("Ran %0d hit words under %0d register settings with sender gaps and stalls.",
			sb.hit_words, settings_run);
		$display("Checked %0d residuals, %0d inside the spacing window, %0d mismatches.",
			sb.results_seen, sb.window_results, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_residuals.size() == 0) begin
			$display("tdc_hit_period_residual_core regression: pass");
		end else begin
			$display("tdc_hit_period_residual_core regression: fail");
		end
		$finish;
	end

endmodule
